[design/wase_pkg.sv]
// Shared types and constants of the window angle speed estimator.
package wase_pkg;

  typedef logic [15:0]        angle_t;
  typedef logic signed [31:0] speed_t;
  typedef logic signed [15:0] delta_t;

  // Configuration register indexes
  localparam int unsigned      IDX_W      = 2;
  localparam logic [IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [IDX_W-1:0] REG_PERIOD = 2'd1;

  localparam int unsigned WINDOW_W    = 7;
  localparam int unsigned PERIOD_W    = 20;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd8;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd50;

  // 60e6 us/min * 1000 mrpm/rpm / 65536 counts/turn = 29296875 / 32
  localparam int unsigned SCALE_W     = 25;
  localparam logic [SCALE_W-1:0] SPEED_SCALE = 25'd29296875;
  localparam int unsigned SCALE_SHIFT = 5;

  localparam int unsigned MAG_W       = 16;
  localparam int unsigned PROD_W      = MAG_W + SCALE_W;
  localparam int unsigned DIVIDEND_W  = PROD_W - SCALE_SHIFT;
  localparam int unsigned DIVISOR_W   = WINDOW_W + PERIOD_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIVIDEND_W);

  localparam logic [DIVIDEND_W-1:0] POS_LIMIT = DIVIDEND_W'(32'h7FFF_FFFF);
  localparam logic [DIVIDEND_W-1:0] NEG_LIMIT = DIVIDEND_W'(32'h8000_0000);
  localparam speed_t SPEED_MAX = 32'sh7FFF_FFFF;
  localparam speed_t SPEED_MIN = 32'sh8000_0000;

endpackage

[design/wase_if.sv]
// Handshake channels for angle samples and speed results.
interface wase_angle_if;
  import wase_pkg::*;
  logic   valid;
  logic   ready;
  angle_t angle;
  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface wase_speed_if;
  import wase_pkg::*;
  logic   valid;
  logic   ready;
  speed_t speed_mrpm;
  logic   speed_valid;
  delta_t angle_delta;
  modport source (output valid, output speed_mrpm, output speed_valid, output angle_delta,
                  input ready);
  modport sink   (input valid, input speed_mrpm, input speed_valid, input angle_delta,
                  output ready);
endinterface

[design/wase_ring.sv]
// Angle history memory: one write port, one read port with registered data.
module wase_ring #(
  parameter int unsigned DEPTH = 65,
  parameter int unsigned AW    = 7
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  wase_pkg::angle_t     wdata,
  input  logic [AW-1:0]        raddr,
  output wase_pkg::angle_t     rdata
);
  import wase_pkg::*;

  angle_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/wase_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module wase_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [wase_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [wase_pkg::DIVISOR_W-1:0]      divisor,
  output logic                                done,
  output logic [wase_pkg::DIVIDEND_W-1:0]     quotient
);
  import wase_pkg::*;

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial    = {rem, quo[DIVIDEND_W-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign diff     = trial - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
      cnt <= DIV_CNT_W'(DIVIDEND_W - 1);
    end else if (busy) begin
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

[design/window_angle_speed_estimator_core.sv]
// Top level of the sliding-window angle speed estimator.
//
// Usage: angle samples enter on the sample channel (valid/ready); every
// accepted word yields exactly one word on the result channel with the
// speed in milli-rpm, a valid flag and the wrapped angle change over the
// window. The angle history sits in a memory of MAX_WINDOW+1 entries.
// Registers are written through wr_en/wr_index/wr_data; the user must write
// them only while idle, which the block itself does not enforce. Writing the
// window register restarts the fill. A word that yields a speed passes the
// states delta, multiply, start, the serial divider, saturate and emit;
// a word taken while the window fills, or with the window or period out of
// range, goes from idle straight to emit. One word is in work at a time;
// sample.ready is high in idle.
// The result sits in an output register, so the next sample is accepted
// while the receiver stalls; a finished result then waits until the
// output register frees up.
// Reset clears the fill state and loads window 8 and period 50 us; the
// memory needs no clearing since every entry is written before it is read.
module window_angle_speed_estimator_core #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [wase_pkg::IDX_W-1:0]          wr_index,
  input  logic [wase_pkg::CFG_DATA_W-1:0]     wr_data,
  wase_angle_if.sink                          sample,
  wase_speed_if.source                        result
);
  import wase_pkg::*;

  localparam int unsigned DEPTH = MAX_WINDOW + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(MAX_WINDOW + 2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DELTA = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SAT   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]          state;
  logic [WINDOW_W-1:0] window;
  logic [PERIOD_W-1:0] period;
  logic [PW-1:0]       wp;
  logic [PW-1:0]       fill;

  angle_t              angle_q;
  delta_t              delta_q;
  logic                neg_q;
  logic [MAG_W-1:0]    mag_q;
  logic [PROD_W-1:0]   prod_q;
  logic [DIVISOR_W-1:0] divisor_q;

  speed_t              res_speed;
  logic                res_valid;
  delta_t              res_delta;

  logic                out_valid;
  speed_t              out_speed;
  logic                out_svalid;
  delta_t              out_delta;

  logic                accept;
  logic                cfg_ok;
  logic [PW-1:0]       size_p;
  logic [PW-1:0]       wp_eff;
  logic [PW-1:0]       wp_inc;
  logic [PW-1:0]       wp_new;
  logic [PW-1:0]       fill_new;
  logic                full;
  angle_t              oldest;
  delta_t              delta_c;
  logic                div_done;
  logic [DIVIDEND_W-1:0] quotient;
  logic                load_out;

  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;

  assign cfg_ok   = (window != '0) && (32'(window) <= MAX_WINDOW) && (period != '0);
  assign size_p   = PW'(window) + PW'(1);
  assign wp_eff   = (wp >= size_p) ? '0 : wp;
  assign wp_inc   = wp_eff + PW'(1);
  assign wp_new   = (wp_inc == size_p) ? '0 : wp_inc;
  assign fill_new = (fill < size_p) ? fill + PW'(1) : fill;
  assign full     = (fill_new == size_p);

  wase_ring #(.DEPTH(DEPTH), .AW(AW)) u_ring (
    .clk   (clk),
    .we    (accept && cfg_ok),
    .waddr (wp_eff[AW-1:0]),
    .wdata (sample.angle),
    .raddr (wp_new[AW-1:0]),
    .rdata (oldest)
  );

  wase_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (prod_q[PROD_W-1:SCALE_SHIFT]),
    .divisor  (divisor_q),
    .done     (div_done),
    .quotient (quotient)
  );

  assign delta_c  = delta_t'(angle_q - oldest);
  assign load_out = (state == S_EMIT) && (!out_valid || result.ready);

  // Control: state, fill tracking, registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      window <= WINDOW_RESET;
      period <= PERIOD_RESET;
      wp     <= '0;
      fill   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cfg_ok) begin
              wp   <= wp_new;
              fill <= fill_new;
            end
            state <= (cfg_ok && full) ? S_DELTA : S_EMIT;
          end
        end
        S_DELTA: state <= S_MUL;
        S_MUL:   state <= S_START;
        S_START: state <= S_DIV;
        S_DIV:   if (div_done) state <= S_SAT;
        S_SAT:   state <= S_EMIT;
        S_EMIT:  if (load_out) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (wr_en) begin
        if (wr_index == REG_WINDOW) begin
          window <= wr_data[WINDOW_W-1:0];
          wp     <= '0;
          fill   <= '0;
        end else if (wr_index == REG_PERIOD) begin
          period <= wr_data[PERIOD_W-1:0];
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      angle_q   <= sample.angle;
      res_speed <= '0;
      res_valid <= 1'b0;
      res_delta <= '0;
    end
    if (state == S_DELTA) begin
      delta_q <= delta_c;
      neg_q   <= delta_c[15];
      mag_q   <= delta_c[15] ? MAG_W'(-delta_c) : MAG_W'(delta_c);
    end
    if (state == S_MUL) begin
      prod_q    <= PROD_W'(mag_q) * PROD_W'(SPEED_SCALE);
      divisor_q <= DIVISOR_W'(window) * DIVISOR_W'(period);
    end
    if (state == S_SAT) begin
      res_valid <= 1'b1;
      res_delta <= delta_q;
      if (!neg_q) begin
        res_speed <= (quotient > POS_LIMIT) ? SPEED_MAX : speed_t'(quotient[31:0]);
      end else begin
        res_speed <= (quotient > NEG_LIMIT) ? SPEED_MIN : speed_t'(-quotient[31:0]);
      end
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_speed  <= res_speed;
      out_svalid <= res_valid;
      out_delta  <= res_delta;
    end
  end

  assign result.valid       = out_valid;
  assign result.speed_mrpm  = out_speed;
  assign result.speed_valid = out_svalid;
  assign result.angle_delta = out_delta;

endmodule
